[rtl/srps_pkg.sv]
package srps_pkg;

    localparam int RegDepth    = 256;
    localparam int PktBufDepth = 256;
    localparam int MaxReadLen  = 59;
    localparam int RegAw       = $clog2(RegDepth);
    localparam int BufAw       = $clog2(PktBufDepth);

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_LWRITE  = 2'd2;
    localparam logic [1:0] OP_LREAD   = 2'd3;

    localparam logic [1:0] CFG_READ_CODE  = 2'd0;
    localparam logic [1:0] CFG_WRITE_CODE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [7:0] HDR_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [7:0] local_addr;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       last;
    } t_out_item;

endpackage

[rtl/serial_register_packet_slave.sv]
// Serial register packet slave. Takes one item per transfer: a serial byte, a
// timer tick, or a local register write/read. Bytes are framed as FF FF len
// instr params checksum; a finished packet writes the 256-byte register file
// and/or emits a status packet on the output channel. A byte, tick or local
// write is accepted in S_IDLE and executed in S_EXEC; a local read adds S_LRD.
// A packet end runs a fetch and check (S_FETCH, S_FWAIT), then the committed
// write bytes (up to 252), the header bytes, the response data bytes (up to 59,
// each read through the registered read port in S_DATA and sent in S_DWAIT) and
// the checksum byte; a stalled output holds the sequence. Power-on clearing
// pass: all 256 register entries are zeroed, during which no item is taken.
module serial_register_packet_slave
    import srps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_EXEC   = 11'b00000000100,
        S_LRD    = 11'b00000001000,
        S_FETCH  = 11'b00000010000,
        S_FWAIT  = 11'b00000100000,
        S_WRLOOP = 11'b00001000000,
        S_HDR    = 11'b00010000000,
        S_DATA   = 11'b00100000000,
        S_DWAIT  = 11'b01000000000,
        S_SUM    = 11'b10000000000
    } t_state;

    t_state r_state;
    t_in_item r_item;
    logic [7:0]  r_read_code, r_write_code;
    logic [15:0] r_timeout;
    logic        r_recv;
    logic [8:0]  r_pos;
    logic [7:0]  r_plen, r_instr, r_sum, r_lastb;
    logic [15:0] r_idle;
    logic [8:0]  r_cnt;
    logic [7:0]  r_addr, r_count, r_status, r_tsum;
    logic [2:0]  r_hidx;
    logic        r_fphase;
    logic [7:0]  r_b4;
    logic        r_ovalid;
    t_out_item   r_odata;

    logic             rf_we;
    logic [RegAw-1:0] rf_waddr, rf_raddr;
    logic [7:0]       rf_wdata, rf_rdata;
    logic             pb_we;
    logic [BufAw-1:0] pb_waddr, pb_raddr;
    logic [7:0]       pb_rdata;

    srps_regfile u_rf (.i_clk, .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
                       .i_raddr(rf_raddr), .o_rdata(rf_rdata));
    srps_pktbuf u_pb (.i_clk, .i_we(pb_we), .i_waddr(pb_waddr), .i_wdata(r_item.data_byte),
                      .i_raddr(pb_raddr), .o_rdata(pb_rdata));

    logic out_free;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    logic [8:0] exec_pos;
    logic       exec_byte_store;
    logic [7:0] bsel;
    assign exec_pos = r_recv ? r_pos : 9'd0;
    assign bsel = r_item.data_byte;
    assign exec_byte_store = (r_state == S_EXEC) && (r_item.opcode == OP_RX_BYTE)
                             && (r_recv || bsel == HDR_BYTE)
                             && (exec_pos < 9'(PktBufDepth));

    always_comb begin
        rf_we = 1'b0;
        rf_waddr = r_cnt[RegAw-1:0];
        rf_wdata = '0;
        rf_raddr = r_item.local_addr[RegAw-1:0];
        pb_we = exec_byte_store;
        pb_waddr = exec_pos[BufAw-1:0];
        pb_raddr = BufAw'(4);
        if (r_state == S_CLEAR) begin
            rf_we = 1'b1;
        end else if (r_state == S_EXEC && r_item.opcode == OP_LWRITE) begin
            rf_we = 1'b1;
            rf_waddr = r_item.local_addr[RegAw-1:0];
            rf_wdata = r_item.data_byte;
        end else if (r_state == S_FETCH) begin
            pb_raddr = r_fphase ? BufAw'(5) : BufAw'(4);
        end else if (r_state == S_WRLOOP) begin
            pb_raddr = BufAw'(9'd5 + r_cnt);
            rf_we = r_fphase;
            rf_waddr = RegAw'(r_addr + 8'(r_cnt) - 8'd1);
            rf_wdata = ((9'd4 + r_cnt) < 9'(PktBufDepth)) ? pb_rdata : 8'd0;
        end else if (r_state == S_DATA || r_state == S_DWAIT) begin
            rf_raddr = RegAw'(r_addr + 8'(r_cnt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_read_code <= 8'd2;
            r_write_code <= 8'd3;
            r_timeout <= 16'd10;
            r_recv <= 1'b0;
            r_pos <= '0;
            r_plen <= '0;
            r_instr <= '0;
            r_sum <= '0;
            r_lastb <= '0;
            r_idle <= '0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_fphase <= 1'b0;
            r_hidx <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_READ_CODE:  r_read_code  <= i_cfg_data[7:0];
                    CFG_WRITE_CODE: r_write_code <= i_cfg_data[7:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt == 9'(RegDepth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    unique case (r_item.opcode)
                        OP_RX_BYTE: begin
                            if (!r_recv && bsel != HDR_BYTE) begin
                                r_pos <= '0;
                                r_sum <= '0;
                            end else begin
                                r_recv <= 1'b1;
                                r_idle <= '0;
                                r_lastb <= bsel;
                                r_pos <= exec_pos + 9'd1;
                                if (!r_recv) begin
                                    r_sum <= '0;
                                end
                                if (exec_pos == 9'd1 && bsel != HDR_BYTE) begin
                                    r_recv <= 1'b0;
                                    r_pos <= exec_pos;
                                end else if (exec_pos == 9'd2 && bsel == HDR_BYTE) begin
                                    r_plen <= bsel;
                                    r_recv <= 1'b0;
                                    r_pos <= exec_pos;
                                end else begin
                                    if (exec_pos == 9'd2) r_plen <= bsel;
                                    if (exec_pos == 9'd3) r_instr <= bsel;
                                    if (exec_pos >= 9'd2) begin
                                        if (exec_pos < ({1'b0, (exec_pos == 9'd2) ? bsel : r_plen}
                                                       + 9'd2)) begin
                                            r_sum <= (r_recv ? r_sum : 8'd0) + bsel;
                                        end else begin
                                            r_recv <= 1'b0;
                                            r_state <= S_FETCH;
                                            r_fphase <= 1'b0;
                                        end
                                    end
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_recv) begin
                                if (r_idle != 16'hFFFF) r_idle <= r_idle + 16'd1;
                                if (((r_idle != 16'hFFFF) ? r_idle + 16'd1 : r_idle)
                                    >= r_timeout) begin
                                    r_recv <= 1'b0;
                                    r_state <= S_FETCH;
                                    r_fphase <= 1'b0;
                                end
                            end
                        end
                        OP_LWRITE: ;
                        OP_LREAD: r_state <= S_LRD;
                        default: ;
                    endcase
                end
                S_LRD: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata <= '{kind: 1'b1, byte_value: rf_rdata, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_FETCH: begin
                    r_fphase <= 1'b1;
                    if (r_fphase) r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    r_hidx <= '0;
                    r_cnt <= '0;
                    r_fphase <= 1'b0;
                    r_count <= '0;
                    r_addr <= '0;
                    r_state <= S_HDR;
                    if (r_pos < 9'd2 || r_lastb != ~r_sum) begin
                        r_status <= 8'd1;
                    end else if (r_instr == r_read_code) begin
                        r_status <= 8'd0;
                        r_addr <= r_b4;
                        r_count <= (pb_rdata > 8'(MaxReadLen)) ? 8'(MaxReadLen) : pb_rdata;
                    end else if (r_instr == r_write_code) begin
                        r_status <= 8'd0;
                        r_addr <= r_b4;
                        if (r_plen > 8'd3) begin
                            r_state <= S_WRLOOP;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WRLOOP: begin
                    r_cnt <= r_cnt + 9'd1;
                    r_fphase <= 1'b1;
                    if (r_fphase && r_cnt == {1'b0, r_plen - 8'd3}) begin
                        r_cnt <= '0;
                        r_fphase <= 1'b0;
                        r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_hidx <= r_hidx + 3'd1;
                        r_odata.kind <= 1'b0;
                        r_odata.last <= 1'b0;
                        case (r_hidx)
                            3'd0, 3'd1: r_odata.byte_value <= HDR_BYTE;
                            3'd2: begin
                                r_odata.byte_value <= r_count + 8'd2;
                                r_tsum <= r_count + 8'd2 + r_status;
                            end
                            default: begin
                                r_odata.byte_value <= r_status;
                                r_state <= (r_count == 8'd0) ? S_SUM : S_DATA;
                            end
                        endcase
                    end
                end
                S_DATA: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata <= '{kind: 1'b0, byte_value: rf_rdata, last: 1'b0};
                        r_tsum <= r_tsum + rf_rdata;
                        r_cnt <= r_cnt + 9'd1;
                        r_state <= (r_cnt + 9'd1 == {1'b0, r_count}) ? S_SUM : S_DATA;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata <= '{kind: 1'b0, byte_value: ~r_tsum, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH && r_fphase) begin
            r_b4 <= pb_rdata;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("item taken during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> (r_ovalid && $stable(r_odata)))
        else $error("result lost under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWAIT) |-> (r_cnt < {1'b0, r_count}))
        else $error("read count overrun");
endmodule

[rtl/srps_regfile.sv]
module srps_regfile
    import srps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [RegAw-1:0]  i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [RegAw-1:0]  i_raddr,
    output logic [7:0]        o_rdata
);
    logic [7:0] r_mem [RegDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/srps_pktbuf.sv]
module srps_pktbuf
    import srps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [BufAw-1:0]  i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [BufAw-1:0]  i_raddr,
    output logic [7:0]        o_rdata
);
    logic [7:0] r_mem [PktBufDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
